/* rtl/rbp_pkg.sv */
package rbp_pkg;

    // Window and count sizing
    localparam int WIN_DEPTH = 64;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int COUNT_W   = 16;
    localparam int BOUND_W   = COUNT_W + 1;
    localparam int ACC_W     = COUNT_W + 4;
    localparam int USED_W    = 7;
    localparam int LIM_W     = 5;
    localparam int SCORE_W   = LIM_W + 1;
    localparam int DEPTH_W   = LIM_W + 1;
    localparam int OUT_W     = ((2 * BOUND_W + USED_W + 3 + 7) / 8) * 8;

    localparam logic [LIM_W-1:0]   LIMIT_RESET = LIM_W'(12);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    // Characters of the notation
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_BRACE   = 3'd1,
        ST_ZERO_BOUND = 3'd2,
        ST_ZERO_UPPER = 3'd3,
        ST_ILLOGICAL  = 3'd4,
        ST_ZERO_INST  = 3'd5,
        ST_INVALID    = 3'd6,
        ST_OVERFLOW   = 3'd7
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_HEAD,
        S_SCAN_GET,
        S_SCAN_EVAL,
        S_SCAN_DONE,
        S_GET,
        S_EVAL,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_VAL_A,
        PH_BLANK1,
        PH_COLON,
        PH_BLANK2,
        PH_VAL_B,
        PH_CLOSE
    } t_phase;

    // Window memory request
    typedef struct packed {
        logic              we;
        logic [WIN_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [WIN_AW-1:0] raddr;
    } t_win_req;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

/* rtl/rbp_window.sv */
module rbp_window
    import rbp_pkg::*;
(
    input  logic       i_clk,
    input  t_win_req   i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] mem [WIN_DEPTH];
    logic [7:0] r_rdata;

    // Character store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rbp_digit_unit.sv */
module rbp_digit_unit
    import rbp_pkg::*;
(
    input  logic [COUNT_W-1:0] i_acc,
    input  logic               i_acc_vld,
    input  logic [7:0]         i_char,
    output logic [COUNT_W-1:0] o_acc,
    output logic               o_sat
);

    logic [7:0]       diff;
    logic [ACC_W-1:0] base;
    logic [ACC_W-1:0] sum;

    // acc * 10 + digit as two shifts and adds, saturated to the count range
    always_comb begin
        diff  = i_char - CH_ZERO;
        base  = i_acc_vld ? ACC_W'(i_acc) : '0;
        sum   = (base << 3) + (base << 1) + ACC_W'(diff[3:0]);
        o_sat = (sum > ACC_W'(COUNT_MAX));
        o_acc = o_sat ? COUNT_MAX : sum[COUNT_W-1:0];
    end

endmodule

/* rtl/repetition_bound_parser.sv */
// Channel   | Direction | Handshake                     | Payload
// ----------+-----------+-------------------------------+-----------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata text_char, tlast text_end,
//           |           |                               | tuser text_empty
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata min, max, consumed, status
// cfg       | in        | i_cfg_valid / o_cfg_ready     | lookahead_limit
//
// A request without tlast or tuser puts its character into the window memory while it has room.
// A closing request starts a parse. A brace is scored over the characters after it (at most
// lookahead_limit of them), then the brace parse reads its positions and steps its fields,
// all through the one read port.
// s_axis_tready is low while a parse runs; a result that m_axis does not take stalls the
// next result only, loading of characters goes on. Reset is synchronous, active low.
module repetition_bound_parser
    import rbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] text_char
    input  logic              s_axis_tlast,
    input  logic              s_axis_tuser,   // [0] text_empty
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // min_count, max_count, consumed, status, zeros
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [LIM_W-1:0]  i_cfg_data
);

    t_state                     r_state, n_state;
    t_phase                     r_phase, n_phase;
    logic [LIM_W-1:0]           r_limit;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [CNT_W-1:0]           r_pos, n_pos;
    logic [LIM_W-1:0]           r_k, n_k;
    logic signed [SCORE_W-1:0]  r_score, n_score;
    logic [DEPTH_W-1:0]         r_depth, n_depth;
    logic                       r_have, n_have;
    logic [COUNT_W-1:0]         r_acc, n_acc;
    logic                       r_acc_vld, n_acc_vld;
    logic [COUNT_W-1:0]         r_a, n_a;
    logic                       r_a_vld, n_a_vld;
    logic                       r_colon, n_colon;
    logic                       r_sat, n_sat;
    logic signed [BOUND_W-1:0]  r_lo, n_lo;
    logic signed [BOUND_W-1:0]  r_hi, n_hi;
    logic [USED_W-1:0]          r_used, n_used;
    t_status                    r_st, n_st;
    logic                       r_ovalid, n_ovalid;
    logic [OUT_W-1:0]           r_odata, n_odata;

    t_win_req                   win_req;
    logic [7:0]                 rdata;
    logic [COUNT_W-1:0]         du_acc;
    logic                       du_sat;
    logic                       in_fire;
    logic [DEPTH_W-1:0]         depth_nx;

    rbp_window u_window (
        .i_clk   (i_clk),
        .i_req   (win_req),
        .o_rdata (rdata)
    );

    rbp_digit_unit u_digit (
        .i_acc     (r_acc),
        .i_acc_vld (r_acc_vld),
        .i_char    (rdata),
        .o_acc     (du_acc),
        .o_sat     (du_sat)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= LIMIT_RESET;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_phase   <= n_phase;
        r_pos     <= n_pos;
        r_k       <= n_k;
        r_score   <= n_score;
        r_depth   <= n_depth;
        r_have    <= n_have;
        r_acc     <= n_acc;
        r_acc_vld <= n_acc_vld;
        r_a       <= n_a;
        r_a_vld   <= n_a_vld;
        r_colon   <= n_colon;
        r_sat     <= n_sat;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_used    <= n_used;
        r_st      <= n_st;
        r_odata   <= n_odata;
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_k       = r_k;
        n_score   = r_score;
        n_depth   = r_depth;
        n_have    = r_have;
        n_acc     = r_acc;
        n_acc_vld = r_acc_vld;
        n_a       = r_a;
        n_a_vld   = r_a_vld;
        n_colon   = r_colon;
        n_sat     = r_sat;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_used    = r_used;
        n_st      = r_st;
        n_odata   = r_odata;
        n_ovalid  = r_ovalid && !m_axis_tready;
        depth_nx  = r_depth;

        win_req       = '0;
        win_req.waddr = r_cnt[WIN_AW-1:0];
        win_req.wdata = s_axis_tdata;
        win_req.raddr = r_pos[WIN_AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (!s_axis_tuser && (r_cnt < CNT_W'(WIN_DEPTH))) begin
                        win_req.we = 1'b1;
                        n_cnt      = r_cnt + 1'b1;
                    end
                    if (s_axis_tlast || s_axis_tuser) begin
                        n_state = S_START;
                    end
                end
            end

            // default 1..1, then fetch the first character if the window is not empty
            S_START: begin
                n_lo   = BOUND_W'(1);
                n_hi   = BOUND_W'(1);
                n_used = '0;
                n_st   = ST_OK;
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    win_req.re    = 1'b1;
                    win_req.raddr = '0;
                    n_state       = S_HEAD;
                end
            end

            // single-character hints or brace start
            S_HEAD: begin
                n_state = S_OUT;
                case (rdata)
                    CH_QUEST: begin
                        n_lo = '0; n_hi = BOUND_W'(1); n_used = USED_W'(1);
                    end
                    CH_STAR: begin
                        n_lo = '0; n_hi = '1; n_used = USED_W'(1);
                    end
                    CH_PLUS: begin
                        n_lo = BOUND_W'(1); n_hi = '1; n_used = USED_W'(1);
                    end
                    CH_OPEN: begin
                        n_score = '0;
                        n_depth = DEPTH_W'(1);
                        n_pos   = CNT_W'(1);
                        n_k     = '0;
                        n_state = S_SCAN_GET;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end

            // lookahead score over the characters after the brace
            S_SCAN_GET: begin
                if ((r_k >= r_limit) || (r_pos >= r_cnt)) begin
                    n_state = S_SCAN_DONE;
                end else begin
                    win_req.re = 1'b1;
                    n_state    = S_SCAN_EVAL;
                end
            end

            S_SCAN_EVAL: begin
                if (is_digit(rdata) || (rdata == CH_COLON) || (rdata == CH_CLOSE)) begin
                    n_score = r_score + SCORE_W'(1);
                end else if (!is_blank(rdata)) begin
                    n_score = r_score - SCORE_W'(1);
                end
                if (rdata == CH_OPEN) begin
                    depth_nx = r_depth + 1'b1;
                end else if (rdata == CH_CLOSE) begin
                    depth_nx = r_depth - 1'b1;
                end
                n_depth = depth_nx;
                if (depth_nx == '0) begin
                    n_state = S_SCAN_DONE;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_k     = r_k + 1'b1;
                    n_state = S_SCAN_GET;
                end
            end

            S_SCAN_DONE: begin
                if (r_score <= 0) begin
                    n_state = S_OUT;
                end else begin
                    n_pos     = CNT_W'(1);
                    n_acc_vld = 1'b0;
                    n_sat     = 1'b0;
                    n_colon   = 1'b0;
                    n_phase   = PH_VAL_A;
                    n_state   = S_GET;
                end
            end

            // fetch the character at the parse position, if any
            S_GET: begin
                n_have     = (r_pos < r_cnt);
                win_req.re = (r_pos < r_cnt);
                n_state    = S_EVAL;
            end

            S_EVAL: begin
                case (r_phase)
                    PH_VAL_A, PH_VAL_B: begin
                        if (r_have && is_digit(rdata)) begin
                            n_acc     = du_acc;
                            n_acc_vld = 1'b1;
                            n_sat     = r_sat || du_sat;
                            n_pos     = r_pos + 1'b1;
                            n_state   = S_GET;
                        end else if (r_phase == PH_VAL_A) begin
                            n_a       = r_acc;
                            n_a_vld   = r_acc_vld;
                            n_acc_vld = 1'b0;
                            n_phase   = PH_BLANK1;
                        end else begin
                            n_phase = PH_CLOSE;
                        end
                    end
                    PH_BLANK1, PH_BLANK2: begin
                        if (r_have && is_blank(rdata)) begin
                            n_pos   = r_pos + 1'b1;
                            n_state = S_GET;
                        end else begin
                            n_phase = (r_phase == PH_BLANK1) ? PH_COLON : PH_VAL_B;
                        end
                    end
                    PH_COLON: begin
                        n_phase = PH_BLANK2;
                        if (r_have && (rdata == CH_COLON)) begin
                            n_colon = 1'b1;
                            n_pos   = r_pos + 1'b1;
                            n_state = S_GET;
                        end
                    end
                    PH_CLOSE: begin
                        n_state = S_OUT;
                        n_lo    = '0;
                        n_hi    = '0;
                        if (!(r_have && (rdata == CH_CLOSE))) begin
                            n_used = USED_W'(r_pos);
                            n_st   = ST_NO_BRACE;
                        end else begin
                            n_used = USED_W'(r_pos + 1'b1);
                            n_st   = r_sat ? ST_OVERFLOW : ST_OK;
                            if (r_a_vld && !r_acc_vld && !r_colon) begin
                                if (r_a == '0) begin
                                    n_st = ST_ZERO_BOUND;
                                end else begin
                                    n_lo = {1'b0, r_a};
                                    n_hi = {1'b0, r_a};
                                end
                            end else if (r_a_vld && !r_acc_vld && r_colon) begin
                                n_lo = {1'b0, r_a};
                                n_hi = '1;
                            end else if (!r_a_vld && r_acc_vld && r_colon) begin
                                if (r_acc == '0) begin
                                    n_st = ST_ZERO_UPPER;
                                end else begin
                                    n_lo = '1;
                                    n_hi = {1'b0, r_acc};
                                end
                            end else if (r_a_vld && r_acc_vld && r_colon) begin
                                if (r_acc < r_a) begin
                                    n_st = ST_ILLOGICAL;
                                end else if ((r_a == '0) && (r_acc == '0)) begin
                                    n_st = ST_ZERO_INST;
                                end else begin
                                    n_lo = {1'b0, r_a};
                                    n_hi = {1'b0, r_acc};
                                end
                            end else begin
                                n_st = ST_INVALID;
                            end
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end

            // hand the result to the output register once it is free
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_odata  = OUT_W'({r_st, r_used, r_hi, r_lo});
                    n_ovalid = 1'b1;
                    n_cnt    = '0;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(WIN_DEPTH))
        else $error("window count beyond depth");

    a_close_starts_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (s_axis_tlast || s_axis_tuser)) |=> (r_state == S_START))
        else $error("closing request did not start a parse");

    a_error_zero_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_odata[2*BOUND_W+USED_W +: 3] != ST_OK)
            && (r_odata[2*BOUND_W+USED_W +: 3] != ST_OVERFLOW))
        |-> (r_odata[2*BOUND_W-1:0] == '0))
        else $error("error result with nonzero bounds");

    a_cnt_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && (n_state == S_IDLE)) |=> (r_cnt == '0) && r_ovalid)
        else $error("window not released after result");

    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_EVAL) |-> (r_pos < r_cnt))
        else $error("scan read beyond loaded characters");

endmodule

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rbp_pkg::*;

    localparam longint COUNT_TOP   = (longint'(1) << COUNT_W) - 1;
    localparam int     SETTLE      = 250;
    localparam int     CYCLE_LIMIT = 2000000;
    localparam int     PHASE_ITEMS = 260;
    localparam int     HOLD_CYCLES = 400;
    localparam int     HOLD_AFTER  = 30;

    // One expected parse result
    typedef struct {
        logic [BOUND_W-1:0] min_count;
        logic [BOUND_W-1:0] max_count;
        logic [USED_W-1:0]  consumed;
        t_status            status;
    } t_bound;

    // Tracks the character window and predicts the bounds of each closing request
    class bound_scoreboard;
        logic [7:0]  window [WIN_DEPTH];
        int unsigned fill;
        int unsigned scan_limit;
        t_bound      bounds_due [$];
        int          errors;

        function new();
            fill       = 0;
            scan_limit = LIMIT_RESET;
            errors     = 0;
        endfunction

        function void set_limit(input logic [LIM_W-1:0] value);
            scan_limit = value;
        endfunction

        function int pending();
            return bounds_due.size();
        endfunction

        function bit digit_char(input logic [7:0] c);
            return (c >= CH_ZERO) && (c <= CH_NINE);
        endfunction

        function bit blank_char(input logic [7:0] c);
            return (c == CH_SPACE) || (c == CH_TAB);
        endfunction

        // Digit run starting at pos, -1 if none; saturates at the count ceiling
        function void read_number(inout int unsigned pos, inout bit sat, output longint value);
            longint d;
            value = -1;
            while (pos < fill && digit_char(window[pos])) begin
                d = window[pos] - CH_ZERO;
                if (value < 0) value = 0;
                if (value > (COUNT_TOP - d) / 10) begin
                    value = COUNT_TOP;
                    sat   = 1'b1;
                end else begin
                    value = value * 10 + d;
                end
                pos++;
            end
        endfunction

        function void skip_blanks(inout int unsigned pos);
            while (pos < fill && blank_char(window[pos])) pos++;
        endfunction

        function void predict_bounds(output longint lo, output longint hi,
                                     output int unsigned used, output t_status st);
            int          score;
            int          nest;
            int unsigned i;
            int unsigned pos;
            longint      a;
            longint      b;
            bit          sat;
            bit          colon;
            logic [7:0]  c;
            lo   = 1;
            hi   = 1;
            used = 0;
            st   = ST_OK;
            if (fill == 0) return;
            c = window[0];
            if (c == CH_QUEST) begin
                lo = 0; hi = 1; used = 1;
                return;
            end
            if (c == CH_STAR) begin
                lo = 0; hi = -1; used = 1;
                return;
            end
            if (c == CH_PLUS) begin
                lo = 1; hi = -1; used = 1;
                return;
            end
            if (c != CH_OPEN) return;

            // lookahead score decides whether the brace is a bound at all
            score = 0;
            nest  = 1;
            i     = 1;
            for (int k = 0; k < scan_limit; k++) begin
                if (i >= fill) break;
                c = window[i];
                if (digit_char(c) || c == CH_COLON || c == CH_CLOSE) score++;
                else if (!blank_char(c)) score--;
                if (c == CH_OPEN) nest++;
                else if (c == CH_CLOSE) nest--;
                if (nest == 0) break;
                i++;
            end
            if (score <= 0) return;

            // brace body: value, blanks, colon, blanks, value, close
            sat = 1'b0;
            pos = 1;
            read_number(pos, sat, a);
            skip_blanks(pos);
            colon = 1'b0;
            if (pos < fill && window[pos] == CH_COLON) begin
                colon = 1'b1;
                pos++;
            end
            skip_blanks(pos);
            read_number(pos, sat, b);
            lo = 0;
            hi = 0;
            if (!(pos < fill && window[pos] == CH_CLOSE)) begin
                used = pos;
                st   = ST_NO_BRACE;
                return;
            end
            pos++;
            used = pos;
            if (a >= 0 && b < 0 && !colon) begin
                if (a == 0) begin
                    st = ST_ZERO_BOUND;
                    return;
                end
                lo = a; hi = a;
            end else if (a >= 0 && b < 0) begin
                lo = a; hi = -1;
            end else if (a < 0 && b >= 0 && colon) begin
                if (b == 0) begin
                    st = ST_ZERO_UPPER;
                    return;
                end
                lo = -1; hi = b;
            end else if (a >= 0 && b >= 0 && colon) begin
                if (b < a) begin
                    st = ST_ILLOGICAL;
                    return;
                end
                if (a == 0 && b == 0) begin
                    st = ST_ZERO_INST;
                    return;
                end
                lo = a; hi = b;
            end else begin
                st = ST_INVALID;
                return;
            end
            if (sat) st = ST_OVERFLOW;
        endfunction

        // Accepted input request
        function void take_char(input logic [7:0] ch, input logic last, input logic empty);
            t_bound      r;
            longint      lo;
            longint      hi;
            int unsigned used;
            t_status     st;
            if (!empty && fill < WIN_DEPTH) begin
                window[fill] = ch;
                fill++;
            end
            if (last || empty) begin
                predict_bounds(lo, hi, used, st);
                if (used > 127) used = 127;
                r.min_count = lo[BOUND_W-1:0];
                r.max_count = hi[BOUND_W-1:0];
                r.consumed  = used[USED_W-1:0];
                r.status    = st;
                bounds_due.push_back(r);
                fill = 0;
            end
        endfunction

        // Accepted output request
        function void check_bounds(input logic [OUT_W-1:0] data);
            t_bound             want;
            logic [BOUND_W-1:0] got_min;
            logic [BOUND_W-1:0] got_max;
            logic [USED_W-1:0]  got_used;
            logic [2:0]         got_st;
            got_min  = data[0 +: BOUND_W];
            got_max  = data[BOUND_W +: BOUND_W];
            got_used = data[2*BOUND_W +: USED_W];
            got_st   = data[2*BOUND_W+USED_W +: 3];
            if (bounds_due.size() == 0) begin
                $display("%0t: result with nothing expected, data %h", $time, data);
                errors++;
                return;
            end
            want = bounds_due.pop_front();
            if (got_min !== want.min_count) begin
                $display("%0t: min_count expected %0d got %0d", $time,
                         $signed(want.min_count), $signed(got_min));
                errors++;
            end
            if (got_max !== want.max_count) begin
                $display("%0t: max_count expected %0d got %0d", $time,
                         $signed(want.max_count), $signed(got_max));
                errors++;
            end
            if (got_used !== want.consumed) begin
                $display("%0t: consumed expected %0d got %0d", $time, want.consumed, got_used);
                errors++;
            end
            if (got_st !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got_st);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;
    logic             s_axis_tlast;
    logic             s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [LIM_W-1:0] i_cfg_data;

    bound_scoreboard  bounds_sb = new();
    logic [7:0]       text_q [$];
    int               items_sent;
    int               results_seen;
    bit               steady;

    repetition_bound_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // Sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (s_axis_tvalid && s_axis_tready)
                bounds_sb.take_char(s_axis_tdata, s_axis_tlast, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) begin
                bounds_sb.check_bounds(m_axis_tdata);
                results_seen++;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off to back the block up
    initial begin : receiver
        bit held;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 37);
        end
    end

    // One character request; returns at the edge where it is taken
    task automatic send_item(input logic [7:0] ch, input logic last, input logic empty);
        int gap;
        @(negedge i_clk);
        if (!steady && $urandom_range(99) < 37) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        s_axis_tuser  <= empty;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Send the queued text, closed on its last character or by an empty request
    task automatic send_text(input bit close_empty);
        for (int n = 0; n < text_q.size(); n++)
            send_item(text_q[n], !close_empty && (n == text_q.size() - 1), 1'b0);
        if (close_empty || text_q.size() == 0)
            send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    endtask

    task automatic load_string(input string s);
        text_q.delete();
        for (int n = 0; n < s.len(); n++) text_q.push_back(s[n]);
    endtask

    function automatic logic [7:0] filler();
        case ($urandom_range(5))
            0, 1: return CH_ZERO + 8'($urandom_range(9));
            2: return $urandom_range(1) ? CH_SPACE : CH_TAB;
            3: return CH_COLON;
            4: return $urandom_range(1) ? CH_CLOSE : CH_OPEN;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic push_number(input bit wide);
        int digits;
        if ($urandom_range(6) == 0) begin
            text_q.push_back(CH_ZERO);
        end else begin
            digits = wide ? $urandom_range(4, 8) : $urandom_range(1, 3);
            repeat (digits) text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
    endtask

    task automatic push_blanks();
        repeat ($urandom_range(2)) text_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    endtask

    // Brace bound with random content; sometimes damaged
    task automatic build_brace(input bit wide);
        int form;
        text_q.push_back(CH_OPEN);
        form = $urandom_range(3);
        if (form != 1) push_number(wide);
        push_blanks();
        if (form != 0) text_q.push_back(CH_COLON);
        push_blanks();
        if (form == 1 || form == 3) push_number(wide);
        if ($urandom_range(9) == 0) text_q.insert($urandom_range(text_q.size()), filler());
        if ($urandom_range(9) != 0) text_q.push_back(CH_CLOSE);
        repeat ($urandom_range(2)) text_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic build_random();
        int kind;
        int n;
        text_q.delete();
        kind = $urandom_range(99);
        if (kind < 10) begin
            // noise
            n = $urandom_range(1, 8);
            repeat (n) text_q.push_back(8'($urandom_range(255)));
        end else if (kind < 20) begin
            // single-character hint
            case ($urandom_range(2))
                0: text_q.push_back(CH_QUEST);
                1: text_q.push_back(CH_STAR);
                default: text_q.push_back(CH_PLUS);
            endcase
            repeat ($urandom_range(3)) text_q.push_back(8'($urandom_range(255)));
        end else if (kind < 93) begin
            build_brace(kind >= 80);
        end else begin
            // long text that can overrun the window
            text_q.push_back(CH_OPEN);
            n = $urandom_range(60, 72);
            repeat (n) text_q.push_back(filler());
        end
    endtask

    // Drop valid, wait for every result, then let the block settle
    task automatic finish_phase();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (bounds_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        bounds_sb.set_limit(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        string directed [11];
        int    plan [6];
        int    target;
        directed = '{"", "?", "*", "+", "x", "{0}", "{:0}", "{2:\t0}", "{7", "{}", "{5:}"};
        plan     = '{31, 1, 0, 12, 0, 2};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        items_sent    = 0;
        results_seen  = 0;
        steady        = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed cases at the reset limit
        foreach (directed[d]) begin
            load_string(directed[d]);
            send_text(directed[d] == "+");
        end

        // random phases, each under its own scan limit
        for (int p = 0; p < 6; p++) begin
            finish_phase();
            write_limit(plan[p] != 0 ? LIM_W'(plan[p]) : LIM_W'($urandom_range(1, 31)));
            steady = (p == 2);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                build_random();
                send_text($urandom_range(9) < 3);
            end
        end
        steady = 1'b0;
        finish_phase();

        if (bounds_sb.errors == 0 && bounds_sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
